// ----- rtl/bra_pkg.sv -----
package bra_pkg;

	localparam int WORD_BITS = 32;
	localparam int IDX_W     = 12;
	localparam int CNT_W     = 13;
	localparam int POS_W     = 13;
	localparam int WPOS_W    = POS_W - 5;
	localparam int CARRY_W   = 14;

	localparam logic [1:0] CMD_FILL  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_SPAN  = 2'd2;
	localparam logic [1:0] CMD_ALLOC = 2'd3;

	// outcome of scanning one store word for a run
	typedef struct packed {
		logic               hit;
		logic [4:0]         hit_bit;
		logic [CARRY_W-1:0] carry;
	} scan_res_t;

endpackage

// ----- rtl/bra_ram.sv -----
module bra_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [bra_pkg::WORD_BITS-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [bra_pkg::WORD_BITS-1:0] rd_data
);
	import bra_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/bra_scan.sv -----
module bra_scan (
	input  logic [bra_pkg::WORD_BITS-1:0] data,
	input  logic                          val,
	input  logic [bra_pkg::WORD_BITS-1:0] keep,
	input  logic [bra_pkg::CARRY_W-1:0]   carry,
	input  logic [bra_pkg::CNT_W-1:0]     cnt,
	output bra_pkg::scan_res_t            res
);
	import bra_pkg::*;

	logic [WORD_BITS-1:0] m;
	logic [WORD_BITS-1:0] tmask;
	logic [WORD_BITS-1:0] gemask;
	logic [WORD_BITS-1:0] acc;
	logic [WORD_BITS-1:0] hit;
	logic [WORD_BITS-1:0] p [0:5];
	logic [5:0]           off;
	logic signed [15:0]   need;
	logic                 local_en;
	logic [4:0]           lo_bit;
	logic [4:0]           lead;

	always_comb begin
		// matching bits, out-of-map bits never match
		m     = ~(data ^ {WORD_BITS{val}}) & keep;
		// ones from bit 0 upward continue the incoming run
		tmask = m & ~(m + 32'd1);
		need  = $signed({3'b0, cnt}) - $signed({2'b0, carry}) - 16'sd1;
		if (need <= 0) begin
			gemask = '1;
		end else if (need >= 32) begin
			gemask = '0;
		end else begin
			gemask = 32'hFFFF_FFFF << need[4:0];
		end

		// p[k][i]: 2^k ones ending at bit i
		p[0] = m;
		for (int k = 1; k < 6; k++) begin
			p[k] = p[k-1] & (p[k-1] << (1 << (k - 1)));
		end
		// window of cnt ones ending at i, built from the binary digits of cnt
		acc = '1;
		off = '0;
		for (int b = 0; b < 6; b++) begin
			if (cnt[b]) begin
				acc = acc & (p[b] << off);
				off = off + 6'(1 << b);
			end
		end
		local_en = (cnt <= 13'd32);

		hit = (gemask & tmask) | (local_en ? acc : '0);

		lo_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				lo_bit = 5'(i);
			end
		end
		lead = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!m[i]) begin
				lead = 5'(WORD_BITS - 1 - i);
			end
		end

		res.hit     = |hit;
		res.hit_bit = lo_bit;
		res.carry   = (&m) ? carry + 14'd32 : CARRY_W'(lead);
	end

endmodule

// ----- rtl/bitmap_run_allocator_unit.sv -----
// Bit map of MAP_BITS bits with first-fit run allocation. A command word is
// taken when start is high and busy is low; each command gives one result word
// on found/start_index/bit_value, marked by done for a single cycle, and the
// receiver cannot stall it. The map lives in one store of MAP_BITS/32 words
// with a registered read, so timing is set by walking that store a word per
// cycle. Fill writes every word, read fetches the word that holds the bit, set
// range reads and writes back each word touched, and allocate scans words up
// to the run's end, then inverts the run through the same walk. Commands that
// change nothing (out-of-range read, empty span, failing allocate length)
// answer in the cycle after acceptance. After reset a clearing pass zeroes the
// store with busy held high; map_size may still be written then.
module bitmap_run_allocator_unit #(
	parameter int MAP_BITS = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                command,
	input  logic [bra_pkg::IDX_W-1:0] index,
	input  logic [bra_pkg::CNT_W-1:0] count,
	input  logic                      value,
	input  logic                      map_size_we,
	input  logic [bra_pkg::CNT_W-1:0] map_size,
	output logic                      done,
	output logic                      found,
	output logic [bra_pkg::IDX_W-1:0] start_index,
	output logic                      bit_value
);
	import bra_pkg::*;

	localparam int WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_FILL   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_RDATA  = 3'd4;
	localparam logic [2:0] ST_SPAN   = 3'd5;
	localparam logic [2:0] ST_SEARCH = 3'd6;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     map_size_q;
	logic [AW-1:0]        fill_q;
	logic                 fill_val_q;

	// word walk: wp_q is the next word to read, pend_* the word whose data is back
	logic [WPOS_W-1:0]    wp_q;
	logic                 issue_q;
	logic                 pend_q;
	logic [WPOS_W-1:0]    pend_wp_q;

	logic [POS_W-1:0]     sp_first_q;
	logic [POS_W-1:0]     sp_last_q;
	logic                 sp_val_q;
	logic                 alloc_q;
	logic [IDX_W-1:0]     alloc_start_q;

	logic [CNT_W-1:0]     cnt_q;
	logic                 val_q;
	logic [POS_W-1:0]     lim_m1_q;
	logic [CARRY_W-1:0]   carry_q;
	logic [4:0]           bit_sel_q;

	logic                 done_q;
	logic                 found_q;
	logic [IDX_W-1:0]     start_q;
	logic                 bitv_q;

	logic [POS_W-1:0]     lim_in;
	logic [POS_W:0]       span_end;
	logic [POS_W-1:0]     span_endc;
	logic [POS_W-1:0]     hit_pos;
	logic [POS_W-1:0]     run_start;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] span_mask;
	logic [WORD_BITS-1:0] span_word;
	logic [WORD_BITS-1:0] keep_mask;
	logic [WORD_BITS-1:0] rd_data;
	scan_res_t            scan_res;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;

	// effective size: map_size clipped to the map
	assign lim_in = (32'(map_size_q) > 32'(MAP_BITS)) ? POS_W'(MAP_BITS) : map_size_q;

	// one bit wider so a long count cannot wrap the span end
	assign span_end  = {2'b0, index} + {1'b0, count};
	assign span_endc = (span_end < {1'b0, lim_in}) ? span_end[POS_W-1:0] : lim_in;

	assign hit_pos   = {pend_wp_q, scan_res.hit_bit};
	assign run_start = hit_pos + 13'd1 - cnt_q;

	// bits of the word under write that fall inside the span
	assign lo_mask   = (pend_wp_q == sp_first_q[POS_W-1:5]) ?
			(32'hFFFF_FFFF << sp_first_q[4:0]) : '1;
	assign hi_mask   = (pend_wp_q == sp_last_q[POS_W-1:5]) ?
			(32'hFFFF_FFFF >> (5'd31 - sp_last_q[4:0])) : '1;
	assign span_mask = lo_mask & hi_mask;
	assign span_word = sp_val_q ? (rd_data | span_mask) : (rd_data & ~span_mask);

	// last searched word is cut at the effective size
	assign keep_mask = (pend_wp_q == lim_m1_q[POS_W-1:5]) ?
			(32'hFFFF_FFFF >> (5'd31 - lim_m1_q[4:0])) : '1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q;
		mem_wdata = {WORD_BITS{fill_val_q}};
		mem_re    = 1'b0;
		mem_raddr = AW'(wp_q);
		case (state_q)
			ST_CLEAR, ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_SPAN: begin
				mem_we    = pend_q;
				mem_waddr = AW'(pend_wp_q);
				mem_wdata = span_word;
				mem_re    = issue_q;
			end
			ST_SEARCH: begin
				mem_re = issue_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	bra_ram #(
		.DEPTH(WORDS),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rd_data(rd_data)
	);

	bra_scan u_scan (
		.data (rd_data),
		.val  (val_q),
		.keep (keep_mask),
		.carry(carry_q),
		.cnt  (cnt_q),
		.res  (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			map_size_q <= 13'd4096;
			fill_q     <= '0;
			fill_val_q <= 1'b0;
			issue_q    <= 1'b0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			found_q    <= 1'b0;
			start_q    <= '0;
			bitv_q     <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			start_q <= '0;
			bitv_q  <= 1'b0;
			if (map_size_we) begin
				map_size_q <= map_size;
			end
			case (state_q)
				ST_CLEAR, ST_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == AW'(WORDS - 1)) begin
						fill_q  <= '0;
						done_q  <= (state_q == ST_FILL);
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (command)
							CMD_FILL: begin
								fill_val_q <= value;
								fill_q     <= '0;
								state_q    <= ST_FILL;
							end
							CMD_READ: begin
								if ({1'b0, index} < lim_in) begin
									wp_q      <= {1'b0, index[IDX_W-1:5]};
									bit_sel_q <= index[4:0];
									state_q   <= ST_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							CMD_SPAN: begin
								if (count == '0 || {1'b0, index} >= lim_in) begin
									done_q <= 1'b1;
								end else begin
									sp_first_q <= {1'b0, index};
									sp_last_q  <= span_endc - 13'd1;
									sp_val_q   <= value;
									alloc_q    <= 1'b0;
									wp_q       <= {1'b0, index[IDX_W-1:5]};
									issue_q    <= 1'b1;
									pend_q     <= 1'b0;
									state_q    <= ST_SPAN;
								end
							end
							CMD_ALLOC: begin
								if (count == '0 || count > lim_in) begin
									done_q <= 1'b1;
								end else begin
									cnt_q    <= count;
									val_q    <= value;
									lim_m1_q <= lim_in - 13'd1;
									carry_q  <= '0;
									wp_q     <= '0;
									issue_q  <= 1'b1;
									pend_q   <= 1'b0;
									state_q  <= ST_SEARCH;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					bitv_q  <= rd_data[bit_sel_q];
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SPAN: begin
					// read ahead one word while the previous one is written back
					if (issue_q) begin
						pend_q    <= 1'b1;
						pend_wp_q <= wp_q;
						wp_q      <= wp_q + 1'b1;
						if (wp_q == sp_last_q[POS_W-1:5]) begin
							issue_q <= 1'b0;
						end
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && pend_wp_q == sp_last_q[POS_W-1:5]) begin
						pend_q  <= 1'b0;
						issue_q <= 1'b0;
						done_q  <= 1'b1;
						found_q <= alloc_q;
						start_q <= alloc_q ? alloc_start_q : '0;
						state_q <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					if (issue_q) begin
						pend_q    <= 1'b1;
						pend_wp_q <= wp_q;
						wp_q      <= wp_q + 1'b1;
						if (wp_q == lim_m1_q[POS_W-1:5]) begin
							issue_q <= 1'b0;
						end
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						if (scan_res.hit) begin
							// run found: invert it through the span walk,
							// the read still in flight is dropped
							sp_first_q    <= run_start;
							sp_last_q     <= hit_pos;
							sp_val_q      <= ~val_q;
							alloc_q       <= 1'b1;
							alloc_start_q <= run_start[IDX_W-1:0];
							wp_q          <= run_start[POS_W-1:5];
							issue_q       <= 1'b1;
							pend_q        <= 1'b0;
							state_q       <= ST_SPAN;
						end else begin
							carry_q <= scan_res.carry;
							if (pend_wp_q == lim_m1_q[POS_W-1:5]) begin
								pend_q  <= 1'b0;
								issue_q <= 1'b0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign start_index = start_q;
	assign bit_value   = bitv_q;

endmodule

// ----- rtl/bra_chk.sv -----
module bra_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic found,
	input logic bit_value
);

	// a result word only ever appears with busy low
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result word while busy");

	// an accepted command either starts work or answers at once
	assert property (@(posedge clk) disable iff (!arst_n)
			(start && !busy) |=> (busy || done))
		else $error("accepted command vanished");

	// busy only rises on an accepted command
	assert property (@(posedge clk) disable iff (!arst_n) $rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// result flags stay low outside a result word, and never both high
	assert property (@(posedge clk) disable iff (!arst_n)
			(found || bit_value) |-> (done && !(found && bit_value)))
		else $error("stray result flags");

endmodule

bind bitmap_run_allocator_unit bra_chk u_chk (.*);

// ----- sim/tb.sv -----
module tb;
	import bra_pkg::*;

	localparam int MAP_BITS       = 4096;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 300;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] start_index;
		logic             bit_value;
	} result_t;

	// Shadow copy of the map; predicts each result word as commands are taken
	class map_scoreboard;
		bit [MAP_BITS-1:0] shadow_map;
		logic [CNT_W-1:0]  shadow_size;
		result_t           awaited[$];
		int                faults;

		function new();
			shadow_map  = '0;
			shadow_size = CNT_W'(4096);
			faults      = 0;
		endfunction

		function void set_size(logic [CNT_W-1:0] v);
			shadow_size = v;
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		// write v over [first, first+n), clipped at the live size
		function void paint(int first, int n, bit v, int lim);
			int i;
			for (i = first; i < lim && i - first < n; i++)
				shadow_map[i] = v;
		endfunction

		function void take_command(logic [1:0] cmd, logic [IDX_W-1:0] idx,
				logic [CNT_W-1:0] cnt, logic val);
			result_t r;
			int      lim;
			int      run;
			int      i;
			int      s;
			r   = '0;
			lim = (int'(shadow_size) < MAP_BITS) ? int'(shadow_size) : MAP_BITS;
			case (cmd)
				CMD_FILL: begin
					shadow_map = {MAP_BITS{val}};
				end
				CMD_READ: begin
					if (int'(idx) < lim)
						r.bit_value = shadow_map[idx];
				end
				CMD_SPAN: begin
					paint(int'(idx), int'(cnt), val, lim);
				end
				CMD_ALLOC: begin
					// first fit: lowest start of cnt equal bits, then invert them
					if (cnt != 0 && int'(cnt) <= lim) begin
						run = 0;
						for (i = 0; i < lim && !r.found; i++) begin
							if (shadow_map[i] == val) begin
								run++;
								if (run == int'(cnt)) begin
									s = i + 1 - int'(cnt);
									paint(s, int'(cnt), !val, lim);
									r.found       = 1'b1;
									r.start_index = s[IDX_W-1:0];
								end
							end else begin
								run = 0;
							end
						end
					end
				end
			endcase
			awaited.push_back(r);
		endfunction

		function void match_result(logic f, logic [IDX_W-1:0] si, logic bv);
			result_t e;
			if (awaited.size() == 0) begin
				$error("result word with no command outstanding");
				faults++;
				return;
			end
			e = awaited.pop_front();
			if (f !== e.found) begin
				$error("found: expected %0d, actual %0d", e.found, f);
				faults++;
			end
			if (si !== e.start_index) begin
				$error("start_index: expected %0d, actual %0d", e.start_index, si);
				faults++;
			end
			if (bv !== e.bit_value) begin
				$error("bit_value: expected %0d, actual %0d", e.bit_value, bv);
				faults++;
			end
		endfunction
	endclass

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic             busy;
	logic [1:0]       command     = CMD_FILL;
	logic [IDX_W-1:0] index       = '0;
	logic [CNT_W-1:0] count       = '0;
	logic             value       = 1'b0;
	logic             map_size_we = 1'b0;
	logic [CNT_W-1:0] cfg_size    = '0;
	logic             done;
	logic             found;
	logic [IDX_W-1:0] start_index;
	logic             bit_value;

	map_scoreboard sb;
	int            idle_pct = 0;
	int            cur_size = 4096;
	int            quiet    = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bitmap_run_allocator_unit #(
		.MAP_BITS(MAP_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.index      (index),
		.count      (count),
		.value      (value),
		.map_size_we(map_size_we),
		.map_size   (cfg_size),
		.done       (done),
		.found      (found),
		.start_index(start_index),
		.bit_value  (bit_value)
	);

	// result check and watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if (arst_n && done)
			sb.match_result(found, start_index, bit_value);
		if (!arst_n || done || (start && !busy) || map_size_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("FAIL bitmap_run_allocator_unit");
			$finish;
		end
	end

	task automatic cmd_word(input logic [1:0] cmd, input int idx, input int cnt,
			input logic val);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		command <= cmd;
		index   <= idx[IDX_W-1:0];
		count   <= cnt[CNT_W-1:0];
		value   <= val;
		start   <= 1'b1;
		do @(posedge clk); while (busy);
		sb.take_command(cmd, idx[IDX_W-1:0], cnt[CNT_W-1:0], val);
	endtask

	// hold off until every result word is back and the block is quiet
	task automatic settle();
		start <= 1'b0;
		while (sb.outstanding() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input int v);
		settle();
		map_size_we <= 1'b1;
		cfg_size    <= v[CNT_W-1:0];
		@(posedge clk);
		map_size_we <= 1'b0;
		sb.set_size(v[CNT_W-1:0]);
		cur_size = v;
	endtask

	// mostly in-range commands on a fragmented map, with some wild fields
	task automatic random_word();
		int         lim;
		int         r;
		int         idx;
		int         cnt;
		logic [1:0] cmd;
		lim = (cur_size < MAP_BITS) ? cur_size : MAP_BITS;
		r   = $urandom_range(0, 99);
		if (r < 6)
			cmd = CMD_FILL;
		else if (r < 30)
			cmd = CMD_READ;
		else if (r < 60)
			cmd = CMD_SPAN;
		else
			cmd = CMD_ALLOC;
		if ($urandom_range(0, 99) < 80)
			idx = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
		else
			idx = $urandom_range(0, 4095);
		r = $urandom_range(0, 99);
		if (r < 70)
			cnt = $urandom_range(1, (lim / 8 > 1) ? lim / 8 : 1);
		else if (r < 80)
			cnt = 0;
		else if (r < 90)
			cnt = $urandom_range(0, lim + 2);
		else
			cnt = $urandom_range(0, 8191);
		cmd_word(cmd, idx, cnt, $urandom_range(0, 1));
	endtask

	int phase_sizes[9] = '{4096, 37, 1, 8191, 200, 64, 4096, 3000, 33};
	int phase_idle[3]  = '{35, 88, 0};

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset size, edges of count and index
		cmd_word(CMD_READ,  0,    0,    1'b0);
		cmd_word(CMD_READ,  4095, 0,    1'b0);
		cmd_word(CMD_ALLOC, 0,    0,    1'b0);    // count zero fails
		cmd_word(CMD_ALLOC, 0,    4097, 1'b0);    // longer than the map
		cmd_word(CMD_ALLOC, 4095, 8191, 1'b1);
		cmd_word(CMD_ALLOC, 0,    4096, 1'b0);    // whole map
		cmd_word(CMD_READ,  4095, 0,    1'b0);
		cmd_word(CMD_ALLOC, 0,    1,    1'b0);    // no fitting run
		cmd_word(CMD_SPAN,  100,  3,    1'b0);
		cmd_word(CMD_ALLOC, 0,    3,    1'b0);
		cmd_word(CMD_SPAN,  4095, 8191, 1'b0);    // clipped at the top
		cmd_word(CMD_ALLOC, 0,    1,    1'b0);
		cmd_word(CMD_SPAN,  5,    0,    1'b0);    // empty span
		cmd_word(CMD_READ,  5,    0,    1'b0);
		cmd_word(CMD_FILL,  0,    0,    1'b0);
		cmd_word(CMD_SPAN,  31,   2,    1'b1);    // straddles a store word
		cmd_word(CMD_ALLOC, 0,    2,    1'b1);
		cmd_word(CMD_FILL,  0,    0,    1'b1);
		settle();

		// small map: reads, spans and runs past the live size
		write_size(37);
		cmd_word(CMD_READ,  37,   0,    1'b0);
		cmd_word(CMD_READ,  36,   0,    1'b0);
		cmd_word(CMD_SPAN,  30,   100,  1'b0);
		cmd_word(CMD_ALLOC, 0,    38,   1'b1);
		cmd_word(CMD_ALLOC, 0,    7,    1'b0);
		cmd_word(CMD_SPAN,  37,   5,    1'b0);

		// zero size: nothing is live
		write_size(0);
		cmd_word(CMD_READ,  0,    0,    1'b0);
		cmd_word(CMD_SPAN,  0,    10,   1'b0);
		cmd_word(CMD_ALLOC, 0,    1,    1'b1);

		// fill reached bits beyond the old size
		write_size(4096);
		cmd_word(CMD_READ,  40,   0,    1'b0);
		cmd_word(CMD_READ,  4095, 0,    1'b0);

		// random: three idling modes, three map sizes in each
		for (int m = 0; m < 3; m++) begin
			idle_pct = phase_idle[m];
			for (int p = 0; p < 3; p++) begin
				write_size(phase_sizes[m * 3 + p]);
				for (int n = 0; n < 56; n++) begin
					if ($urandom_range(0, 99) < 2)
						settle();
					random_word();
				end
			end
		end

		start <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d result words never arrived", sb.outstanding());
			sb.faults++;
		end
		if (sb.faults == 0)
			$display("PASS bitmap_run_allocator_unit");
		else
			$display("FAIL bitmap_run_allocator_unit");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/bra_pkg.sv
rtl/bra_ram.sv
rtl/bra_scan.sv
rtl/bitmap_run_allocator_unit.sv
rtl/bra_chk.sv
sim/tb.sv
